>>> rtl/sdspi_pkg.sv
// Shared types, codes and the CRC7 step for the SD SPI command and read engine.
package sdspi_pkg;

	localparam int unsigned MAX_BLOCK_BYTES = 512;
	localparam logic [9:0] MAX_BLOCK = 10'(MAX_BLOCK_BYTES);

	localparam logic [7:0] CMD_START = 8'h40;
	localparam logic [7:0] TOKEN_START = 8'hFE;
	localparam logic [7:0] BYTE_IDLE = 8'hFF;
	localparam logic [6:0] CRC7_POLY = 7'h09;
	localparam int unsigned FRAME_BYTES = 6;

	localparam logic [1:0] CFG_RESPONSE_TRIES = 2'd0;
	localparam logic [1:0] CFG_TOKEN_TRIES = 2'd1;
	localparam logic [1:0] CFG_BLOCK_BYTES = 2'd2;

	typedef enum logic [1:0] {
		MODE_CMD = 2'd0,
		MODE_RX = 2'd1,
		MODE_READ = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TX = 2'd0,
		KIND_RESP = 2'd1,
		KIND_DATA = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_WAIT_R1 = 3'd1,
		PH_WAIT_TOKEN = 3'd2,
		PH_DATA = 3'd3,
		PH_CRC1 = 3'd4,
		PH_CRC2 = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] response_tries;
		logic [9:0] token_tries;
		logic [9:0] block_bytes;
	} cfg_t;

	// result set of one item: a whole frame, a single beat, or nothing
	typedef struct packed {
		logic frame;
		logic one;
		kind_t kind;
		logic [7:0] value;
		logic ok;
		logic last;
	} res_t;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	function automatic logic [6:0] crc7_byte(input logic [6:0] c_in, input logic [7:0] b);
		logic [6:0] c;
		logic fb;
		c = c_in;
		for (int i = 7; i >= 0; i--) begin
			fb = b[i] ^ c[6];
			c = {c[5:0], 1'b0};
			if (fb) begin
				c = c ^ CRC7_POLY;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/sdspi_framer.sv
// Command frame builder: start byte, argument and CRC7 end byte.
module sdspi_framer import sdspi_pkg::*; (
	input  logic [5:0]  cmd_index,
	input  logic [31:0] argument,
	output frame_t      frame
);

	logic [6:0] crc [0:5];

	always_comb begin
		frame[0] = CMD_START | {2'b00, cmd_index};
		frame[1] = argument[31:24];
		frame[2] = argument[23:16];
		frame[3] = argument[15:8];
		frame[4] = argument[7:0];
		crc[0] = 7'h00;
		for (int k = 0; k < 5; k++) begin
			crc[k+1] = crc7_byte(crc[k], frame[k]);
		end
		frame[5] = {crc[5], 1'b1};
	end

endmodule

>>> rtl/sdspi_ctrl.sv
// Phase tracking, try and byte counters, and result selection per item.
module sdspi_ctrl import sdspi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic       adv,
	input  logic [1:0] mode,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output res_t       res
);

	phase_t phase_q, phase_d;
	logic [9:0] tries_q, tries_d;
	logic [9:0] bytes_q, bytes_d;
	logic [9:0] tries_dec, bytes_dec, blk_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tries_q <= '0;
			bytes_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			tries_q <= tries_d;
			bytes_q <= bytes_d;
		end
	end

	assign tries_dec = (tries_q != '0) ? tries_q - 10'd1 : '0;
	assign bytes_dec = (bytes_q != '0) ? bytes_q - 10'd1 : '0;

	always_comb begin
		if (cfg.block_bytes == '0) begin
			blk_n = 10'd1;
		end else if (cfg.block_bytes > MAX_BLOCK) begin
			blk_n = MAX_BLOCK;
		end else begin
			blk_n = cfg.block_bytes;
		end
	end

	always_comb begin
		phase_d = phase_q;
		tries_d = tries_q;
		bytes_d = bytes_q;
		res = '{frame: 1'b0, one: 1'b0, kind: KIND_TX, value: 8'h00, ok: 1'b0, last: 1'b0};
		if (valid) begin
			unique case (mode_t'(mode))
				MODE_CMD: begin
					res.frame = 1'b1;
					phase_d = PH_WAIT_R1;
					tries_d = (cfg.response_tries != '0) ? {2'b00, cfg.response_tries} : 10'd1;
					bytes_d = '0;
				end
				MODE_READ: begin
					phase_d = PH_WAIT_TOKEN;
					tries_d = (cfg.token_tries != '0) ? cfg.token_tries : 10'd1;
					bytes_d = '0;
				end
				MODE_RX: begin
					unique case (phase_q)
						PH_WAIT_R1: begin
							res.kind = KIND_RESP;
							res.value = rx_byte;
							if (!rx_byte[7]) begin
								res.one = 1'b1;
								res.ok = 1'b1;
								phase_d = PH_IDLE;
								tries_d = '0;
							end else begin
								tries_d = tries_dec;
								if (tries_dec == '0) begin
									res.one = 1'b1;
									phase_d = PH_IDLE;
								end
							end
						end
						PH_WAIT_TOKEN: begin
							res.kind = KIND_STATUS;
							if (rx_byte == TOKEN_START) begin
								bytes_d = blk_n;
								tries_d = '0;
								phase_d = PH_DATA;
							end else if (rx_byte == BYTE_IDLE && tries_dec != '0) begin
								tries_d = tries_dec;
							end else begin
								// stray byte or tries used up
								res.one = 1'b1;
								phase_d = PH_IDLE;
								tries_d = '0;
							end
						end
						PH_DATA: begin
							res.one = 1'b1;
							res.kind = KIND_DATA;
							res.value = rx_byte;
							res.ok = 1'b1;
							res.last = (bytes_dec == '0);
							bytes_d = bytes_dec;
							if (bytes_dec == '0) begin
								phase_d = PH_CRC1;
							end
						end
						PH_CRC1: begin
							phase_d = PH_CRC2;
						end
						PH_CRC2: begin
							res.one = 1'b1;
							res.kind = KIND_STATUS;
							res.ok = 1'b1;
							phase_d = PH_IDLE;
						end
						PH_IDLE: begin
						end
						default: begin
							phase_d = PH_IDLE;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/sdspi_outbuf.sv
// Result register: holds a six byte frame or a single beat and shifts it out.
module sdspi_outbuf import sdspi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       res,
	input  frame_t     frame,
	input  logic       out_stall,
	output logic       can_load,
	output logic       out_valid,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic       ok,
	output logic       last
);

	frame_t data_q;
	logic [2:0] rem_q;
	kind_t kind_q;
	logic ok_q, last_q;
	logic pop;

	assign out_valid = (rem_q != '0);
	assign pop = out_valid && !out_stall;
	assign can_load = (rem_q == '0) || (rem_q == 3'd1 && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load && res.frame) begin
			rem_q <= 3'(FRAME_BYTES);
		end else if (load && res.one) begin
			rem_q <= 3'd1;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.frame) begin
			data_q <= frame;
			kind_q <= KIND_TX;
			ok_q <= 1'b0;
			last_q <= 1'b1;
		end else if (load && res.one) begin
			data_q[0] <= res.value;
			kind_q <= res.kind;
			ok_q <= res.ok;
			last_q <= res.last;
		end else if (pop) begin
			data_q <= {8'h00, data_q[FRAME_BYTES-1:1]};
		end
	end

	assign kind = kind_q;
	assign value = data_q[0];
	assign ok = ok_q;
	assign last = last_q && (rem_q == 3'd1);

endmodule

>>> rtl/sd_spi_command_and_read_engine_core.sv
// Top level of the SD card SPI mode command and block read engine.
//
// Input channel (in_valid / in_stall): one beat per item. mode 0 frames a
// command (cmd_index, argument) into six transmit beats ending in the CRC7
// byte, mode 1 hands over a byte received from the card, mode 2 arms a
// block read. mode 3 is dropped.
// Output channel (out_valid / out_stall): kind, value, ok, last per beat.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; index 0 response tries, 1 token tries, 2 block bytes, others ignored.
//
// Path: an accepted item is held in the input register; its first result beat
// is then registered in the result register, which drives the output.
// Throughput: one item per cycle while results go one beat each and out_stall
// is low. A command frame occupies the result register for six beats, and the
// input register holds the next result-bearing item until the last frame beat
// leaves. An item with no result passes the input register without waiting.
// When the receiver stalls, the current beat holds and in_stall rises as
// soon as the input register has an item waiting for the result register.
// Reset: idle phase, counters cleared, registers back to 10 / 201 / 512,
// both channels empty.
module sd_spi_command_and_read_engine_core import sdspi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [5:0]  cmd_index,
	input  logic [31:0] argument,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  value,
	output logic        ok,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	cfg_t cfg_q;

	// input register
	logic valid_s1;
	logic [1:0] mode_s1;
	logic [5:0] idx_s1;
	logic [31:0] arg_s1;
	logic [7:0] rx_s1;

	logic accept, adv, can_load;
	res_t res;
	frame_t frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.response_tries <= 8'd10;
			cfg_q.token_tries <= 10'd201;
			cfg_q.block_bytes <= 10'd512;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RESPONSE_TRIES: cfg_q.response_tries <= cfg_data[7:0];
				CFG_TOKEN_TRIES:    cfg_q.token_tries <= cfg_data;
				CFG_BLOCK_BYTES:    cfg_q.block_bytes <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// an item leaves the input register when its results fit the result register
	assign adv = valid_s1 && ((!res.frame && !res.one) || can_load);
	assign in_stall = valid_s1 && !adv;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			idx_s1 <= cmd_index;
			arg_s1 <= argument;
			rx_s1 <= rx_byte;
		end
	end

	sdspi_framer u_framer (
		.cmd_index (idx_s1),
		.argument  (arg_s1),
		.frame     (frame)
	);

	sdspi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (valid_s1),
		.adv     (adv),
		.mode    (mode_s1),
		.rx_byte (rx_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	sdspi_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (res),
		.frame     (frame),
		.out_stall (out_stall),
		.can_load  (can_load),
		.out_valid (out_valid),
		.kind      (kind),
		.value     (value),
		.ok        (ok),
		.last      (last)
	);

endmodule
